/* sv/bba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Types, codes and defaults shared by the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int TREE_LEVELS_DEF    = 10;
    localparam int MIN_BLOCK_LOG2_DEF = 5;
    localparam logic [4:0] HEADER_RESET = 5'd24;

    typedef enum logic [1:0] {
        NODE_ABSENT = 2'd0,
        NODE_FREE   = 2'd1,
        NODE_ALLOC  = 2'd2,
        NODE_SPLIT  = 2'd3
    } node_code_t;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    typedef struct packed {
        logic        func;
        logic [15:0] alloc_size;
        logic [14:0] free_address;
    } req_t;

    typedef struct packed {
        logic [14:0] address;
        logic [1:0]  status;
    } rsp_t;

endpackage

/* sv/bba_node_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_node_ram
// Node state memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bba_node_ram
    import bba_pkg::*;
#(
    parameter int AW = 11
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  node_code_t    wr_data,
    input  logic [AW-1:0] rd_addr,
    output node_code_t    rd_data
);

    node_code_t mem [0:(1 << AW) - 1];
    node_code_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/buddy_block_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a 2^(MIN_BLOCK_LOG2+TREE_LEVELS) byte region.
//
// Channels: req (valid/ready) carries one allocate or free beat; rsp
// (valid/ready) returns one beat per request with address and status;
// cfg (valid/ready, always ready) writes the header size in bytes.
// Flow: a request scans the node memory once in heap order, one node
// per cycle; an allocate then splits level by level, and a free merges
// level by level while the buddy is free. A zero-size allocate skips
// the scan and answers no-fit. One request is in flight at a time, and
// req_ready stays low until the result is handed to the output register.
// Reset: all 2^(TREE_LEVELS+1) node entries are cleared one per cycle,
// the root to free, before req_ready rises; the header returns to 24 bytes.
// A stalled receiver holds the result in the output register; the next
// request may be accepted meanwhile and its result waits behind it.
// ----------------------------------------------------------------------------
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int TREE_LEVELS    = TREE_LEVELS_DEF,
    parameter int MIN_BLOCK_LOG2 = MIN_BLOCK_LOG2_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_t       req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_t       rsp,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data
);

    localparam int TOP = MIN_BLOCK_LOG2 + TREE_LEVELS;
    localparam int NW  = TREE_LEVELS + 1;
    localparam int CW  = (TOP + 1 > 17) ? TOP + 1 : 17;
    localparam int LW  = $clog2(TREE_LEVELS + 1);
    localparam logic [CW-1:0] REGION  = CW'(1) << TOP;
    localparam logic [NW-1:0] LAST    = {NW{1'b1}};
    localparam logic [NW-1:0] ROOT    = NW'(1);
    localparam logic [LW-1:0] LV_LAST = LW'(TREE_LEVELS);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_SPLIT, S_SPLIT2, S_MFREE, S_MCHK, S_MBUD, S_FIN
    } state_t;

    state_t        state_reg;
    logic [NW-1:0] clr_reg;
    logic [4:0]    hdr_reg;
    logic          func_reg;
    logic [CW-1:0] need_reg;
    logic [CW-1:0] addr_reg;

    logic [NW-1:0] scan_idx_reg;
    logic [LW-1:0] scan_lv_reg;
    logic [CW-1:0] scan_off_reg;
    logic [CW-1:0] scan_blk_reg;
    logic          issue_done_reg;

    logic          p_valid_reg;
    logic [NW-1:0] p_idx_reg;
    logic [LW-1:0] p_lv_reg;
    logic [CW-1:0] p_off_reg;
    logic [CW-1:0] p_blk_reg;

    logic          hit_reg;
    logic [NW-1:0] cur_idx_reg;
    logic [LW-1:0] cur_lv_reg;
    logic [CW-1:0] cur_off_reg;
    logic [CW-1:0] cur_blk_reg;

    logic [14:0]   res_addr_reg;
    logic [1:0]    res_status_reg;
    logic          rsp_valid_reg;
    rsp_t          rsp_reg;

    logic          wr_en;
    logic [NW-1:0] wr_addr;
    node_code_t    wr_data;
    logic [NW-1:0] rd_addr;
    node_code_t    rd_data;

    logic          split_go;
    logic          issue;
    logic [CW-1:0] off_step;
    logic [CW-1:0] p_pay;
    logic [CW-1:0] cur_pay;

    bba_node_ram #(
        .AW (NW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign split_go = (cur_lv_reg < LV_LAST) && (need_reg <= (cur_blk_reg >> 1));
    assign issue    = (state_reg == S_SCAN) && !issue_done_reg;
    assign off_step = scan_off_reg + scan_blk_reg;
    assign p_pay    = p_off_reg + CW'(hdr_reg);
    assign cur_pay  = cur_off_reg + CW'(hdr_reg);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cur_idx_reg;
        wr_data = NODE_ABSENT;
        rd_addr = (state_reg == S_MFREE) ? (cur_idx_reg ^ ROOT) : scan_idx_reg;
        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = (clr_reg == ROOT) ? NODE_FREE : NODE_ABSENT;
            end
            S_SPLIT:
            begin
                wr_en   = 1'b1;
                wr_data = split_go ? NODE_SPLIT : NODE_ALLOC;
            end
            S_SPLIT2:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_idx_reg | ROOT;
                wr_data = NODE_FREE;
            end
            S_MFREE:
            begin
                wr_en   = 1'b1;
                wr_data = NODE_FREE;
            end
            S_MCHK:
            begin
                wr_en   = (rd_data == NODE_FREE);
            end
            S_MBUD:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_idx_reg ^ ROOT;
            end
            default:
            begin
                wr_en   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            hdr_reg        <= HEADER_RESET;
            issue_done_reg <= 1'b0;
            p_valid_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                hdr_reg <= cfg_data;
            end
            if (state_reg == S_FIN && (!rsp_valid_reg || rsp_ready))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            p_valid_reg <= issue;
            p_idx_reg   <= scan_idx_reg;
            p_lv_reg    <= scan_lv_reg;
            p_off_reg   <= scan_off_reg;
            p_blk_reg   <= scan_blk_reg;

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + NW'(1);
                    if (clr_reg == LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        func_reg       <= req.func;
                        need_reg       <= CW'(req.alloc_size) + CW'(hdr_reg);
                        addr_reg       <= CW'(req.free_address);
                        scan_idx_reg   <= ROOT;
                        scan_lv_reg    <= '0;
                        scan_off_reg   <= '0;
                        scan_blk_reg   <= REGION;
                        issue_done_reg <= 1'b0;
                        hit_reg        <= 1'b0;
                        if (req.func == FUNC_ALLOC && req.alloc_size == 16'd0)
                        begin
                            res_addr_reg   <= '0;
                            res_status_reg <= ST_NO_FIT;
                            state_reg      <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (issue)
                    begin
                        scan_idx_reg <= scan_idx_reg + NW'(1);
                        if (scan_idx_reg == LAST)
                        begin
                            issue_done_reg <= 1'b1;
                        end
                        if (off_step == REGION)
                        begin
                            scan_off_reg <= '0;
                            scan_lv_reg  <= scan_lv_reg + LW'(1);
                            scan_blk_reg <= scan_blk_reg >> 1;
                        end
                        else
                        begin
                            scan_off_reg <= off_step;
                        end
                    end
                    if (p_valid_reg)
                    begin
                        if (func_reg == FUNC_ALLOC)
                        begin
                            if (rd_data == NODE_FREE && need_reg <= p_blk_reg &&
                                (!hit_reg || p_lv_reg > cur_lv_reg))
                            begin
                                hit_reg     <= 1'b1;
                                cur_idx_reg <= p_idx_reg;
                                cur_lv_reg  <= p_lv_reg;
                                cur_off_reg <= p_off_reg;
                                cur_blk_reg <= p_blk_reg;
                            end
                        end
                        else if (rd_data == NODE_ALLOC && p_pay == addr_reg && !hit_reg)
                        begin
                            hit_reg     <= 1'b1;
                            cur_idx_reg <= p_idx_reg;
                            cur_lv_reg  <= p_lv_reg;
                            cur_off_reg <= p_off_reg;
                            cur_blk_reg <= p_blk_reg;
                        end
                    end
                    else if (issue_done_reg)
                    begin
                        if (!hit_reg)
                        begin
                            res_addr_reg   <= '0;
                            res_status_reg <= (func_reg == FUNC_ALLOC) ? ST_NO_FIT
                                                                       : ST_BAD_FREE;
                            state_reg      <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= (func_reg == FUNC_ALLOC) ? S_SPLIT : S_MFREE;
                        end
                    end
                end
                S_SPLIT:
                begin
                    if (split_go)
                    begin
                        cur_idx_reg <= {cur_idx_reg[NW-2:0], 1'b0};
                        cur_lv_reg  <= cur_lv_reg + LW'(1);
                        cur_blk_reg <= cur_blk_reg >> 1;
                        state_reg   <= S_SPLIT2;
                    end
                    else
                    begin
                        res_addr_reg   <= cur_pay[14:0];
                        res_status_reg <= ST_OK;
                        state_reg      <= S_FIN;
                    end
                end
                S_SPLIT2:
                begin
                    state_reg <= S_SPLIT;
                end
                S_MFREE:
                begin
                    if (cur_idx_reg > ROOT)
                    begin
                        state_reg <= S_MCHK;
                    end
                    else
                    begin
                        res_addr_reg   <= '0;
                        res_status_reg <= ST_OK;
                        state_reg      <= S_FIN;
                    end
                end
                S_MCHK:
                begin
                    if (rd_data == NODE_FREE)
                    begin
                        state_reg <= S_MBUD;
                    end
                    else
                    begin
                        res_addr_reg   <= '0;
                        res_status_reg <= ST_OK;
                        state_reg      <= S_FIN;
                    end
                end
                S_MBUD:
                begin
                    cur_idx_reg <= {1'b0, cur_idx_reg[NW-1:1]};
                    state_reg   <= S_MFREE;
                end
                S_FIN:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_reg   <= '{address: res_addr_reg, status: res_status_reg};
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.address == '0)
        else $error("failed result carries a nonzero address");

    a_no_write_node0: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && state_reg != S_CLEAR |-> wr_addr != '0)
        else $error("write to unused node zero");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SPLIT |-> cur_lv_reg <= LV_LAST)
        else $error("split went below the deepest level");

    a_merge_root: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MBUD |-> cur_idx_reg > ROOT)
        else $error("merge attempted above the root");
`endif

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the buddy block allocator. A behavioral copy of the
// buddy tree predicts each response beat. Directed tests cover the special
// cases: zero size, oversize, tiny and large headers, bad and double frees,
// and a header change with live blocks. Random phases then mix alloc/free
// sequences with noise under bursty requests, with a stalling receiver in alternate phases.
// ----------------------------------------------------------------------------
module testbench;
    import bba_pkg::*;

    localparam int TL       = TREE_LEVELS_DEF;
    localparam int TOP_LOG2 = MIN_BLOCK_LOG2_DEF + TREE_LEVELS_DEF;
    localparam int NODES    = 1 << (TL + 1);
    localparam int LIMIT    = 20000000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    req_t       req = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    rsp_t       rsp;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [4:0] cfg_data = '0;

    node_code_t tree_state [NODES];
    int         hdr_bytes;
    rsp_t       pending_rsp [$];
    int         mismatches = 0;
    int         cycles = 0;
    int         burst_left = 0;
    bit         stall_on = 1'b0;

    buddy_block_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int node_level(int idx);
        int lv;
        lv = 0;
        while ((2 << lv) <= idx)
            lv++;
        return lv;
    endfunction

    function automatic int node_base(int idx);
        int lv;
        lv = node_level(idx);
        return (idx - (1 << lv)) << (TOP_LOG2 - lv);
    endfunction

    function automatic rsp_t predict_outcome(req_t r);
        rsp_t o;
        int   found;
        int   flev;
        int   need;
        o = '0;
        found = 0;
        flev = 0;
        if (r.func == FUNC_ALLOC)
        begin
            need = int'(r.alloc_size) + hdr_bytes;
            if (r.alloc_size == 0)
            begin
                o.status = ST_NO_FIT;
                return o;
            end
            for (int lv = TL; lv >= 0 && found == 0; lv--)
            begin
                if (need > (1 << (TOP_LOG2 - lv)))
                    continue;
                for (int i = 1 << lv; i < (2 << lv); i++)
                begin
                    if (tree_state[i] == NODE_FREE)
                    begin
                        found = i;
                        flev = lv;
                        break;
                    end
                end
            end
            if (found == 0)
            begin
                o.status = ST_NO_FIT;
                return o;
            end
            while (flev < TL && need <= ((1 << (TOP_LOG2 - flev)) / 2))
            begin
                tree_state[found] = NODE_SPLIT;
                found = found * 2;
                flev++;
                tree_state[found + 1] = NODE_FREE;
            end
            tree_state[found] = NODE_ALLOC;
            o.address = 15'(node_base(found) + hdr_bytes);
            o.status = ST_OK;
        end
        else
        begin
            for (int lv = 0; lv <= TL && found == 0; lv++)
            begin
                for (int i = 1 << lv; i < (2 << lv); i++)
                begin
                    if (tree_state[i] == NODE_ALLOC &&
                        node_base(i) + hdr_bytes == int'(r.free_address))
                    begin
                        found = i;
                        break;
                    end
                end
            end
            if (found == 0)
            begin
                o.status = ST_BAD_FREE;
                return o;
            end
            tree_state[found] = NODE_FREE;
            while (found > 1 && tree_state[found ^ 1] == NODE_FREE)
            begin
                tree_state[found] = NODE_ABSENT;
                tree_state[found ^ 1] = NODE_ABSENT;
                found = found >> 1;
                tree_state[found] = NODE_FREE;
            end
            o.status = ST_OK;
        end
        return o;
    endfunction

    function automatic int pick_live_address();
        int live [$];
        for (int i = 1; i < NODES; i++)
            if (tree_state[i] == NODE_ALLOC)
                live.push_back(node_base(i) + hdr_bytes);
        if (live.size() == 0)
            return -1;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response beat addr=%0d status=%0d",
                             rsp.address, rsp.status);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.address !== want.address || rsp.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected addr=%0d status=%0d, got addr=%0d status=%0d",
                                 want.address, want.status, rsp.address, rsp.status);
                end
            end
        end
        if (rst_n && req_valid && req_ready)
            pending_rsp.push_back(predict_outcome(req));
        if (rst_n && cfg_valid && cfg_ready)
            hdr_bytes = int'(cfg_data);
    end

    always @(negedge clk)
    begin
        if (!stall_on)
            rsp_ready <= 1'b1;
        else
            rsp_ready <= (cycles % 64) >= 20 ? ($urandom_range(0, 3) != 0) : 1'b0;
    end

    task automatic send_req(input logic func, input int size, input int addr);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(0, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge clk);
        req <= '{func: func, alloc_size: 16'(size), free_address: 15'(addr)};
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    task automatic alloc(input int size);
        send_req(FUNC_ALLOC, size, $urandom_range(0, 32767));
    endtask

    task automatic free_addr(input int addr);
        send_req(FUNC_FREE, $urandom_range(0, 65535), addr);
    endtask

    task automatic wait_idle();
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_header(input int value);
        wait_idle();
        @(negedge clk);
        cfg_data <= 5'(value);
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic free_all_live();
        int a;
        a = pick_live_address();
        while (a >= 0)
        begin
            free_addr(a);
            a = pick_live_address();
        end
    endtask

    task automatic test_directed();
        int a;
        alloc(0);
        alloc(32768);
        alloc(32744);
        free_addr(24);
        free_addr(24);
        free_addr(0);
        alloc(1);
        alloc(8);
        alloc(9);
        a = pick_live_address();
        free_addr(a);
        free_all_live();
        write_header(0);
        alloc(32768);
        free_addr(0);
        alloc(32);
        alloc(33);
        write_header(31);
        alloc(1);
        alloc(2);
        free_addr(32767);
        write_header(0);
        free_all_live();
        write_header(31);
        alloc(32737);
        alloc(32738);
        free_all_live();
    endtask

    task automatic test_random_phase(input int hdr, input int count);
        int a;
        int pick;
        write_header(hdr);
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 42)
            begin
                a = pick_live_address();
                if (a < 0)
                    alloc($urandom_range(1, 200));
                else
                    free_addr(a);
            end
            else if (pick < 48)
                free_addr($urandom_range(0, 32767));
            else if (pick < 50)
                alloc(0);
            else if (pick < 80)
                alloc($urandom_range(1, 100));
            else if (pick < 93)
                alloc($urandom_range(1, 4000));
            else if (pick < 97)
                alloc($urandom_range(4000, 32768));
            else
                alloc($urandom_range(0, 1) ? 32768 : 32767);
        end
    endtask

    task automatic test_random();
        int hdrs [6];
        hdrs = '{0, 31, 24, 8, 0, 31};
        for (int p = 0; p < 6; p++)
        begin
            stall_on = p[0];
            test_random_phase(p == 3 ? $urandom_range(0, 31) : hdrs[p], 220);
        end
    endtask

    initial
    begin
        for (int i = 0; i < NODES; i++)
            tree_state[i] = NODE_ABSENT;
        tree_state[1] = NODE_FREE;
        hdr_bytes = int'(HEADER_RESET);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        stall_on = 1'b1;
        test_directed();
        test_random();
        wait_idle();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
